// ===== rtl/sobel_gradient_energy_map_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Sobel gradient energy map
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_ENERGY_MAP_ASSERT_SVH
`define SOBEL_GRADIENT_ENERGY_MAP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SGEM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SGEM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sgem_pkg.sv =====
// ----------------------------------------------------------------------------
// sgem_pkg
// Shared types and constants of the Sobel gradient energy map.
// ----------------------------------------------------------------------------
package sgem_pkg;

   localparam int MAX_WIDTH_DEFAULT = 2048;

   localparam int DIM_W       = 12;
   localparam int PIX_W       = 8;
   localparam int ENERGY_W    = 11;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_INDEX_W = 1;

   localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;

   // BT.601 luma weights, 14-bit fixed point
   localparam int GRAY_SUM_W = 22;
   localparam logic [13:0] GRAY_WB = 14'd1868;
   localparam logic [13:0] GRAY_WG = 14'd9617;
   localparam logic [13:0] GRAY_WR = 14'd4899;
   localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = 22'd8192;

   // result queue
   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // control that travels with one item down the pipeline
   typedef struct packed {
      logic valid;
      logic pixel;      // 0 = drain item
      logic row_one;
      logic col_one;
      logic emit_mid;   // result for the previous column
      logic emit_last;  // result for the last column
   } ctl_type;

   // one window column: row above, middle row, row below
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } col_type;

   typedef struct packed {
      logic                frame_end;
      logic [ENERGY_W-1:0] energy;
   } entry_type;

   typedef struct packed {
      logic      valid_a;
      entry_type entry_a;
      logic      valid_b;
      entry_type entry_b;
   } push_type;

endpackage

// ===== rtl/sgem_gray.sv =====
// ----------------------------------------------------------------------------
// sgem_gray
// BGR to 8-bit gray with rounding, BT.601 weights.
// ----------------------------------------------------------------------------
module sgem_gray (
   input  logic [sgem_pkg::PIX_W-1:0] blue,
   input  logic [sgem_pkg::PIX_W-1:0] green,
   input  logic [sgem_pkg::PIX_W-1:0] red,
   output logic [sgem_pkg::PIX_W-1:0] gray
);

   logic [sgem_pkg::GRAY_SUM_W-1:0] prod_b;
   logic [sgem_pkg::GRAY_SUM_W-1:0] prod_g;
   logic [sgem_pkg::GRAY_SUM_W-1:0] prod_r;
   logic [sgem_pkg::GRAY_SUM_W-1:0] sum;

   assign prod_b = sgem_pkg::GRAY_SUM_W'(blue)  * sgem_pkg::GRAY_SUM_W'(sgem_pkg::GRAY_WB);
   assign prod_g = sgem_pkg::GRAY_SUM_W'(green) * sgem_pkg::GRAY_SUM_W'(sgem_pkg::GRAY_WG);
   assign prod_r = sgem_pkg::GRAY_SUM_W'(red)   * sgem_pkg::GRAY_SUM_W'(sgem_pkg::GRAY_WR);
   assign sum    = prod_b + prod_g + prod_r + sgem_pkg::GRAY_ROUND;
   assign gray   = sum[sgem_pkg::GRAY_SUM_W-1 -: sgem_pkg::PIX_W];

endmodule

// ===== rtl/sgem_line_buf.sv =====
// ----------------------------------------------------------------------------
// sgem_line_buf
// Two line stores holding the gray rows r-2 and r-1, and the new window
// column built from them.
// ----------------------------------------------------------------------------
module sgem_line_buf #(
   parameter int MAX_WIDTH = sgem_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
   input  logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
   input  sgem_pkg::ctl_type               ctl,
   input  logic [sgem_pkg::PIX_W-1:0]      gray,
   output sgem_pkg::col_type               column
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic [sgem_pkg::PIX_W-1:0] older_mem [MAX_WIDTH];
   logic [sgem_pkg::PIX_W-1:0] newer_mem [MAX_WIDTH];
   logic [sgem_pkg::PIX_W-1:0] older_q_ff;
   logic [sgem_pkg::PIX_W-1:0] newer_q_ff;
   logic                       wr_en;

   assign wr_en = ctl.valid & ctl.pixel;

   // read one column ahead; the write of the previous item never hits the same entry
   always_ff @(posedge clock) begin
      older_q_ff <= older_mem[rd_addr];
      newer_q_ff <= newer_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         older_mem[wr_addr] <= newer_q_ff;
         newer_mem[wr_addr] <= gray;
      end
   end

   always_comb begin
      column.mid = newer_q_ff;
      if (ctl.pixel) begin
         column.top = ctl.row_one ? gray : older_q_ff;
         column.bot = gray;
      end else begin
         // mirror the row below onto row r-2
         column.top = older_q_ff;
         column.bot = older_q_ff;
      end
   end

   logic unused_aw;
   assign unused_aw = (AW > 0);

endmodule

// ===== rtl/sgem_window.sv =====
// ----------------------------------------------------------------------------
// sgem_window
// 3x3 gray window and the L1 Sobel energy of its center, up to two results
// per item.
// ----------------------------------------------------------------------------
module sgem_window (
   input  logic                clock,
   input  logic                reset,
   input  sgem_pkg::ctl_type   ctl,
   input  sgem_pkg::col_type   column,
   output logic                busy,
   output sgem_pkg::push_type  push
);

   sgem_pkg::col_type win_ff [3];
   sgem_pkg::ctl_type ctl_ff;
   sgem_pkg::col_type left_mid;
   logic [sgem_pkg::ENERGY_W-1:0] energy_mid;
   logic [sgem_pkg::ENERGY_W-1:0] energy_last;

   function automatic logic [9:0] wsum(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      wsum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
   endfunction

   function automatic logic [9:0] absdiff(input logic [9:0] a, input logic [9:0] b);
      absdiff = (a >= b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [10:0] sobel_energy(input sgem_pkg::col_type l,
                                                input sgem_pkg::col_type m,
                                                input sgem_pkg::col_type r);
      logic [9:0] av;
      logic [9:0] ah;
      av = absdiff(wsum(l.bot, m.bot, r.bot), wsum(l.top, m.top, r.top));
      ah = absdiff(wsum(r.top, r.mid, r.bot), wsum(l.top, l.mid, l.bot));
      sobel_energy = {1'b0, av} + {1'b0, ah};
   endfunction

   always_ff @(posedge clock) begin
      if (ctl.valid) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= column;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

   // at column one the left neighbor mirrors the right one
   assign left_mid    = ctl_ff.col_one ? win_ff[2] : win_ff[0];
   assign energy_mid  = sobel_energy(left_mid, win_ff[1], win_ff[2]);
   assign energy_last = sobel_energy(win_ff[1], win_ff[2], win_ff[1]);

   always_comb begin
      push.valid_a          = ctl_ff.valid & (ctl_ff.emit_mid | ctl_ff.emit_last);
      push.valid_b          = ctl_ff.valid & ctl_ff.emit_mid & ctl_ff.emit_last;
      push.entry_b.energy    = energy_last;
      push.entry_b.frame_end = ~ctl_ff.pixel;
      if (ctl_ff.emit_mid) begin
         push.entry_a.energy    = energy_mid;
         push.entry_a.frame_end = 1'b0;
      end else begin
         push.entry_a = push.entry_b;
      end
   end

   assign busy = ctl_ff.valid;

endmodule

// ===== rtl/sgem_out_fifo.sv =====
// ----------------------------------------------------------------------------
// sgem_out_fifo
// Result queue: takes up to two items per cycle, hands out one.
// ----------------------------------------------------------------------------
module sgem_out_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  sgem_pkg::push_type                push,
   input  logic                              pop,
   output logic                              not_empty,
   output sgem_pkg::entry_type               head,
   output logic [sgem_pkg::OUT_CNT_W-1:0]    count
);

   sgem_pkg::entry_type mem_ff [sgem_pkg::OUT_DEPTH];
   logic [sgem_pkg::OUT_PTR_W-1:0] wr_ptr_ff;
   logic [sgem_pkg::OUT_PTR_W-1:0] wr_ptr_in;
   logic [sgem_pkg::OUT_PTR_W-1:0] wr_ptr_b;
   logic [sgem_pkg::OUT_PTR_W-1:0] rd_ptr_ff;
   logic [sgem_pkg::OUT_PTR_W-1:0] rd_ptr_in;
   logic [sgem_pkg::OUT_CNT_W-1:0] count_ff;
   logic [sgem_pkg::OUT_CNT_W-1:0] count_in;
   logic                           do_pop;

   assign do_pop   = pop & not_empty;
   assign wr_ptr_b = wr_ptr_ff + sgem_pkg::OUT_PTR_W'(push.valid_a);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + sgem_pkg::OUT_PTR_W'(push.valid_a)
                            + sgem_pkg::OUT_PTR_W'(push.valid_b);
      rd_ptr_in = rd_ptr_ff + sgem_pkg::OUT_PTR_W'(do_pop);
      count_in  = count_ff + sgem_pkg::OUT_CNT_W'(push.valid_a)
                           + sgem_pkg::OUT_CNT_W'(push.valid_b)
                           - sgem_pkg::OUT_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid_a) begin
         mem_ff[wr_ptr_ff] <= push.entry_a;
      end
      if (push.valid_b) begin
         mem_ff[wr_ptr_b] <= push.entry_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ===== rtl/sobel_gradient_energy_map.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_energy_map
// Streaming L1 Sobel energy of a BGR frame with reflect-101 borders.
// ----------------------------------------------------------------------------
// One item per clock while req_tready is high. An accepted item is
// registered, converted to gray and merged with the two line stores in the
// next cycle, then shifted into the 3x3 window registers, and its results
// enter an eight-entry output queue and are offered from its head. Results
// come one row behind the input; the last item of a row gives two results,
// which the queue drains at one per clock when rsp_tready is high. The block
// takes an item whenever the queue has room for the worst case of everything
// in flight, so with rsp_tready held high req_tready stays high. After the
// last row send one drain item (req_tuser high) per column; an item of the
// wrong kind is taken and dropped. The line stores need no clearing after
// reset. Change the registers only while no frame data is in flight.
// ----------------------------------------------------------------------------
module sobel_gradient_energy_map #(
   parameter int MAX_WIDTH = sgem_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sgem_pkg::REQ_TDATA_W-1:0]    req_tdata,  // blue, green, red
   input  logic                                req_tuser,  // cmd
   // results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sgem_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // energy, zero fill
   output logic                                rsp_tlast,  // frame_end
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sgem_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sgem_pkg::DIM_W-1:0]          csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int NW = sgem_pkg::OUT_CNT_W + 1;

   logic [sgem_pkg::DIM_W-1:0] image_width_ff;
   logic [sgem_pkg::DIM_W-1:0] image_height_ff;
   logic [sgem_pkg::DIM_W-1:0] row_count_ff;
   logic [sgem_pkg::DIM_W-1:0] row_count_in;
   logic [AW-1:0]              column_count_ff;
   logic [AW-1:0]              column_count_in;
   logic [AW-1:0]              last_col;
   logic [sgem_pkg::DIM_W-1:0] eff_height;

   logic drain;
   logic last;
   logic active;
   logic accept;
   logic item_ok;
   logic advance;

   sgem_pkg::ctl_type ctl_in;
   sgem_pkg::ctl_type ctl_ff;
   logic [AW-1:0]                addr_ff;
   logic [sgem_pkg::PIX_W-1:0]   blue_ff;
   logic [sgem_pkg::PIX_W-1:0]   green_ff;
   logic [sgem_pkg::PIX_W-1:0]   red_ff;
   logic [sgem_pkg::PIX_W-1:0]   gray;
   sgem_pkg::col_type            column;
   sgem_pkg::push_type           push;
   sgem_pkg::entry_type          head;
   logic                         win_busy;
   logic [sgem_pkg::OUT_CNT_W-1:0] fifo_count;
   logic [NW-1:0]                need;
   sgem_pkg::csr_index_type      csr_sel;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;
   assign csr_sel   = sgem_pkg::csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= sgem_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= sgem_pkg::IMAGE_HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_sel)
            sgem_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data;
            sgem_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_data;
         endcase
      end
   end

   // clamp width to [2, MAX_WIDTH], height to at least 2
   always_comb begin
      if (image_width_ff < sgem_pkg::DIM_W'(2)) begin
         last_col = AW'(1);
      end else if (int'(image_width_ff) >= MAX_WIDTH) begin
         last_col = AW'(MAX_WIDTH - 1);
      end else begin
         last_col = AW'(image_width_ff - sgem_pkg::DIM_W'(1));
      end
      eff_height = (image_height_ff < sgem_pkg::DIM_W'(2)) ? sgem_pkg::DIM_W'(2)
                                                          : image_height_ff;
   end

   // ---------------- item control ----------------
   assign need = NW'(fifo_count) + NW'({ctl_ff.valid, 1'b0}) + NW'({win_busy, 1'b0})
               + NW'(2);
   assign req_tready = (need <= NW'(sgem_pkg::OUT_DEPTH));
   assign accept     = req_tvalid & req_tready;

   assign drain   = (row_count_ff >= eff_height);
   assign item_ok = (req_tuser == drain);
   assign advance = accept & item_ok;
   assign last    = (column_count_ff >= last_col);
   assign active  = drain | (row_count_ff != '0);

   always_comb begin
      ctl_in.valid     = advance;
      ctl_in.pixel     = ~drain;
      ctl_in.row_one   = (row_count_ff == sgem_pkg::DIM_W'(1));
      ctl_in.col_one   = (column_count_ff == AW'(1));
      ctl_in.emit_mid  = active & (column_count_ff != '0);
      ctl_in.emit_last = active & last;

      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (advance) begin
         if (last) begin
            column_count_in = '0;
            row_count_in    = drain ? '0 : row_count_ff + sgem_pkg::DIM_W'(1);
         end else begin
            column_count_in = column_count_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= '0;
         column_count_ff <= '0;
         ctl_ff          <= '0;
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         ctl_ff          <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= column_count_ff;
      blue_ff  <= req_tdata[7:0];
      green_ff <= req_tdata[15:8];
      red_ff   <= req_tdata[23:16];
   end

   // ---------------- datapath ----------------
   sgem_gray u_gray (
      .blue  (blue_ff),
      .green (green_ff),
      .red   (red_ff),
      .gray  (gray)
   );

   sgem_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .rd_addr (column_count_ff),
      .wr_addr (addr_ff),
      .ctl     (ctl_ff),
      .gray    (gray),
      .column  (column)
   );

   sgem_window u_window (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl_ff),
      .column (column),
      .busy   (win_busy),
      .push   (push)
   );

   sgem_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_tready),
      .not_empty (rsp_tvalid),
      .head      (head),
      .count     (fifo_count)
   );

   assign rsp_tdata = sgem_pkg::RSP_TDATA_W'(head.energy);
   assign rsp_tlast = head.frame_end;

   // ---------------- assertions ----------------
`include "sobel_gradient_energy_map_assert.svh"

   `SGEM_ASSERT_NOW(a_queue_bound, 1'b1, fifo_count <= sgem_pkg::OUT_CNT_W'(sgem_pkg::OUT_DEPTH), "result queue overflow")
   `SGEM_ASSERT_NEXT(a_frame_wrap, advance && drain && last, row_count_ff == '0 && column_count_ff == '0, "counters not cleared at frame end")
   `SGEM_ASSERT_NEXT(a_drop_item, accept && !item_ok, $stable(row_count_ff) && $stable(column_count_ff), "dropped item moved the counters")

endmodule
